/* rtl/core/paid_pkg.sv */
// Shared types and codes for the positional list store.
// Used by positional_array_insert_delete; no dependencies.
package paid_pkg;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned COUNT_W = 7;

    // Input beat
    typedef struct packed {
        logic [1:0]               command;
        logic [POS_W-1:0]         position;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
    } out_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_FINAL = 4'b0100,
        S_READ  = 4'b1000
    } state_t;

endpackage

/* rtl/core/paid_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module paid_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/positional_array_insert_delete.sv */
// Positional list store: controller plus entry RAM.
// Depends on paid_pkg and paid_ram.
//
// Usage: raise start with a request beat while busy is low. Each command gives exactly one
// result beat, shown on result for one cycle while result_valid is high; it cannot be held
// off. Entries live in one RAM with one write and one read port, so an insert or delete
// moves one entry per cycle. Rejected commands and an insert at count+1 return their result
// in the next cycle without raising busy. A read holds busy while in S_READ, then answers.
// A delete moves each later entry down one slot in S_SHIFT (none when the last entry goes).
// An insert moves each entry from the last down to the target up one slot in S_SHIFT, then
// writes the new value into the opened slot in S_FINAL.
module positional_array_insert_delete #(
    parameter int unsigned DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  paid_pkg::in_t request,
    output logic          result_valid,
    output paid_pkg::out_t result
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = ((CW > paid_pkg::POS_W) ? CW : paid_pkg::POS_W) + 1;
    localparam int unsigned VW = paid_pkg::VALUE_W;

    paid_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [AW-1:0]    tgt_reg, tgt_next;
    logic [VW-1:0]    val_reg, val_next;
    logic             ins_reg, ins_next;
    logic [1:0]       status_reg, status_next;
    logic [VW-1:0]    rdval_reg, rdval_next;
    logic             result_valid_reg, result_valid_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VW-1:0]    ram_rdata;

    logic             accept;
    logic [WW-1:0]    pos_ext;
    logic [WW-1:0]    cnt_ext;
    logic [WW-1:0]    pos_m1;
    logic [WW-1:0]    cnt_m1;
    logic [WW-1:0]    src_p1;
    logic             pos_nz;
    logic             full;

    paid_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Position and count arithmetic
    assign accept  = start && !busy;
    assign pos_ext = WW'(request.position);
    assign cnt_ext = WW'(count_reg);
    assign pos_m1  = pos_ext - WW'(1);
    assign cnt_m1  = cnt_ext - WW'(1);
    assign src_p1  = WW'(src_reg) + WW'(1);
    assign pos_nz  = (pos_ext != '0);
    assign full    = (cnt_ext == WW'(DEPTH));

    // Controller
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        src_next          = src_reg;
        tgt_next          = tgt_reg;
        val_next          = val_reg;
        ins_next          = ins_reg;
        status_next       = status_reg;
        rdval_next        = rdval_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = src_reg;
        ram_wdata         = ram_rdata;
        ram_raddr         = src_reg;

        unique case (state_reg)
            paid_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next = paid_pkg::ST_BADPOS;
                    rdval_next  = '0;
                    priority if (request.command == paid_pkg::CMD_INSERT)
                    begin
                        if (pos_nz && (pos_ext <= cnt_ext + WW'(1)))
                        begin
                            if (full)
                            begin
                                status_next       = paid_pkg::ST_FULL;
                                result_valid_next = 1'b1;
                            end
                            else if (pos_m1 == cnt_ext)
                            begin
                                // append: no entries move
                                ram_we            = 1'b1;
                                ram_waddr         = AW'(cnt_ext);
                                ram_wdata         = request.value;
                                count_next        = count_reg + CW'(1);
                                status_next       = paid_pkg::ST_OK;
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                // start moving from the last entry downward
                                ram_raddr  = AW'(cnt_m1);
                                src_next   = AW'(cnt_m1);
                                tgt_next   = AW'(pos_m1);
                                val_next   = request.value;
                                ins_next   = 1'b1;
                                state_next = paid_pkg::S_SHIFT;
                            end
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                        end
                    end
                    else if (request.command == paid_pkg::CMD_DELETE)
                    begin
                        if (pos_nz && (pos_ext <= cnt_ext))
                        begin
                            if (pos_ext == cnt_ext)
                            begin
                                // last entry goes: no entries move
                                count_next        = count_reg - CW'(1);
                                status_next       = paid_pkg::ST_OK;
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                // first entry to move down sits at index position
                                ram_raddr  = AW'(pos_ext);
                                src_next   = AW'(pos_ext);
                                ins_next   = 1'b0;
                                state_next = paid_pkg::S_SHIFT;
                            end
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                        end
                    end
                    else if (request.command == paid_pkg::CMD_READ)
                    begin
                        if (pos_nz && (pos_ext <= cnt_ext))
                        begin
                            ram_raddr  = AW'(pos_m1);
                            state_next = paid_pkg::S_READ;
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                    end
                end
            end

            paid_pkg::S_SHIFT:
            begin
                // write back the entry read last cycle, one slot over
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (ins_reg)
                begin
                    ram_waddr = AW'(src_p1);
                    if (src_reg == tgt_reg)
                    begin
                        state_next = paid_pkg::S_FINAL;
                    end
                    else
                    begin
                        ram_raddr = src_reg - AW'(1);
                        src_next  = src_reg - AW'(1);
                    end
                end
                else
                begin
                    ram_waddr = src_reg - AW'(1);
                    if (src_p1 == cnt_ext)
                    begin
                        count_next        = count_reg - CW'(1);
                        status_next       = paid_pkg::ST_OK;
                        result_valid_next = 1'b1;
                        state_next        = paid_pkg::S_IDLE;
                    end
                    else
                    begin
                        ram_raddr = AW'(src_p1);
                        src_next  = AW'(src_p1);
                    end
                end
            end

            paid_pkg::S_FINAL:
            begin
                // drop the new value into the opened slot
                ram_we            = 1'b1;
                ram_waddr         = tgt_reg;
                ram_wdata         = val_reg;
                count_next        = count_reg + CW'(1);
                status_next       = paid_pkg::ST_OK;
                result_valid_next = 1'b1;
                state_next        = paid_pkg::S_IDLE;
            end

            paid_pkg::S_READ:
            begin
                status_next       = paid_pkg::ST_OK;
                rdval_next        = ram_rdata;
                result_valid_next = 1'b1;
                state_next        = paid_pkg::S_IDLE;
            end

            default:
            begin
                state_next = paid_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= paid_pkg::S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        tgt_reg    <= tgt_next;
        val_reg    <= val_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    // Outputs; count_reg already holds the post-command count at the strobe
    assign busy                = (state_reg != paid_pkg::S_IDLE);
    assign result_valid        = result_valid_reg;
    assign result.status       = status_reg;
    assign result.read_value   = rdval_reg;
    assign result.entry_count  = cnt_ext[paid_pkg::COUNT_W-1:0];

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= WW'(DEPTH))
        else $error("entry count above depth");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (state_reg == paid_pkg::S_IDLE))
        else $error("result strobe while a command is in progress");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || result_valid_reg))
        else $error("accepted command neither started nor answered");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (status_reg == paid_pkg::ST_FULL)) |-> full)
        else $error("full status with room left");

    a_shift_ports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == paid_pkg::S_SHIFT) |-> (ram_waddr != ram_raddr))
        else $error("move step reads the entry it writes");

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for positional_array_insert_delete: directed and random
// insert, delete and read commands, checked against an in-bench list model.
// Depends on paid_pkg and the positional_array_insert_delete RTL.
module testbench;

    localparam int unsigned LIST_DEPTH = 64;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;   // no operation, always rejected
    localparam int          MAX_REPORTS = 10;

    // Mix of commands inside one random phase
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } phase_mix_t;

    // One queued command with its lead-in idle time
    typedef struct {
        paid_pkg::in_t beat;
        int  gap;
        bit  wait_drained;   // hold off until all replies are back
    } command_slot_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    paid_pkg::in_t  request = '0;
    logic           busy;
    logic           result_valid;
    paid_pkg::out_t result;

    command_slot_t  commands_waiting[$];
    paid_pkg::out_t replies_due[$];

    // List model owned by the bench
    logic signed [paid_pkg::VALUE_W-1:0] shadow_list[LIST_DEPTH];
    int unsigned                         shadow_count = 0;

    int             idle_left = 0;
    int             mismatch_total = 0;
    paid_pkg::out_t reply_want;

    positional_array_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result)
    );

    // 20-unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the bench list and return the reply it should give
    function automatic paid_pkg::out_t list_apply(paid_pkg::in_t beat);
        paid_pkg::out_t reply;
        int unsigned    pos;
        reply.status     = paid_pkg::ST_BADPOS;
        reply.read_value = '0;
        pos = beat.position;
        case (beat.command)
            paid_pkg::CMD_INSERT:
            begin
                if (pos >= 1 && pos <= shadow_count + 1)
                begin
                    if (shadow_count >= LIST_DEPTH)
                        reply.status = paid_pkg::ST_FULL;
                    else
                    begin
                        for (int i = shadow_count; i > pos - 1; i--)
                            shadow_list[i] = shadow_list[i-1];
                        shadow_list[pos-1] = beat.value;
                        shadow_count++;
                        reply.status = paid_pkg::ST_OK;
                    end
                end
            end
            paid_pkg::CMD_DELETE:
            begin
                if (pos >= 1 && pos <= shadow_count)
                begin
                    for (int i = pos - 1; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    reply.status = paid_pkg::ST_OK;
                end
            end
            paid_pkg::CMD_READ:
            begin
                if (pos >= 1 && pos <= shadow_count)
                begin
                    reply.read_value = shadow_list[pos-1];
                    reply.status     = paid_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        reply.entry_count = paid_pkg::COUNT_W'(shadow_count);
        return reply;
    endfunction

    task automatic note_mismatch(string what, paid_pkg::out_t want, paid_pkg::out_t got);
        mismatch_total++;
        if (mismatch_total <= MAX_REPORTS)
            $display({"mismatch (%s): want status=%0d value=%0d count=%0d, ",
                      "got status=%0d value=%0d count=%0d"},
                     what, want.status, want.read_value, want.entry_count,
                     got.status, got.read_value, got.entry_count);
    endtask

    // Queue one command; the generator keeps its own count to aim positions
    task automatic queue_command(logic [1:0] cmd, int pos,
                                 logic signed [paid_pkg::VALUE_W-1:0] val,
                                 ref int count);
        command_slot_t slot;
        slot.beat.command  = cmd;
        slot.beat.position = paid_pkg::POS_W'(pos);
        slot.beat.value    = val;
        slot.gap           = $urandom_range(0, 18);
        slot.wait_drained  = 1'b0;
        commands_waiting.push_back(slot);
        if (cmd == paid_pkg::CMD_INSERT && pos >= 1 && pos <= count + 1 && count < LIST_DEPTH)
            count++;
        else if (cmd == paid_pkg::CMD_DELETE && pos >= 1 && pos <= count)
            count--;
    endtask

    // Random value with the extremes showing up often
    function automatic logic signed [paid_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'sd0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Driver: present the next command, keep start high across back-to-back beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            request   <= '0;
            idle_left <= 0;
        end
        else if (start && !busy)
        begin
            replies_due.push_back(list_apply(request));
            if (commands_waiting.size() != 0 && commands_waiting[0].gap == 0
                && !commands_waiting[0].wait_drained)
            begin
                request <= commands_waiting[0].beat;
                void'(commands_waiting.pop_front());
            end
            else
            begin
                start <= 1'b0;
                if (commands_waiting.size() != 0)
                    idle_left <= commands_waiting[0].gap;
            end
        end
        else if (!start && commands_waiting.size() != 0)
        begin
            if (idle_left != 0)
                idle_left <= idle_left - 1;
            else if (!commands_waiting[0].wait_drained || replies_due.size() == 0)
            begin
                request <= commands_waiting[0].beat;
                start   <= 1'b1;
                void'(commands_waiting.pop_front());
            end
        end
    end

    // Monitor: each strobed reply against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (replies_due.size() == 0)
                note_mismatch("no reply due", '0, result);
            else
            begin
                reply_want = replies_due.pop_front();
                if (result.status !== reply_want.status
                    || result.read_value !== reply_want.read_value
                    || result.entry_count !== reply_want.entry_count)
                    note_mismatch("reply fields", reply_want, result);
            end
        end
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("** positional_array_insert_delete: FAILED **");
        $finish;
    end

    // Stimulus, reset and end of run
    initial
    begin
        int          gen_count;
        int          random_done;
        int          phase_len;
        int          roll;
        bit          no_idle;
        phase_mix_t  mix;
        logic [1:0]  cmd;
        int          pos;

        gen_count   = 0;
        random_done = 0;

        // Directed: empty list, both ends, middle, extremes of every field
        queue_command(paid_pkg::CMD_READ,   1,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_DELETE, 1,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_INSERT, 0,   32'sd7,        gen_count);
        queue_command(paid_pkg::CMD_INSERT, 2,   32'sd7,        gen_count);
        queue_command(paid_pkg::CMD_INSERT, 1,   32'h7fff_ffff, gen_count);
        queue_command(paid_pkg::CMD_INSERT, 2,   32'h8000_0000, gen_count);
        queue_command(paid_pkg::CMD_INSERT, 1,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_INSERT, 2,   32'hffff_ffff, gen_count);
        queue_command(paid_pkg::CMD_INSERT, 6,   32'sd1,        gen_count);
        for (int p = 1; p <= 4; p++)
            queue_command(paid_pkg::CMD_READ, p, 32'sd0, gen_count);
        queue_command(paid_pkg::CMD_READ,   5,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_READ,   127, 32'hffff_ffff, gen_count);
        queue_command(paid_pkg::CMD_READ,   0,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_DELETE, 2,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_DELETE, 3,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_DELETE, 4,   32'sd0,        gen_count);
        queue_command(CMD_UNUSED,           1,   32'hffff_ffff, gen_count);
        queue_command(paid_pkg::CMD_DELETE, 127, 32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_DELETE, 1,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_READ,   1,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_DELETE, 1,   32'sd0,        gen_count);
        queue_command(paid_pkg::CMD_INSERT, 127, 32'h5555_5555, gen_count);

        // Random phases: mostly inserts, mostly deletes, or mixed traffic
        while (random_done < 1850)
        begin
            roll = $urandom_range(0, 2);
            mix = (roll == 0) ? MIX_FILL : (roll == 1) ? MIX_DRAIN : MIX_EVEN;
            phase_len = $urandom_range(30, 160);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && random_done < 1850; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    cmd = CMD_UNUSED;
                else if (mix == MIX_FILL)
                    cmd = (roll < 80) ? paid_pkg::CMD_INSERT
                        : (roll < 92) ? paid_pkg::CMD_READ : paid_pkg::CMD_DELETE;
                else if (mix == MIX_DRAIN)
                    cmd = (roll < 75) ? paid_pkg::CMD_DELETE
                        : (roll < 88) ? paid_pkg::CMD_READ : paid_pkg::CMD_INSERT;
                else
                    cmd = (roll < 35) ? paid_pkg::CMD_INSERT
                        : (roll < 65) ? paid_pkg::CMD_DELETE : paid_pkg::CMD_READ;

                // Mostly legal positions, ends favored; the rest anywhere
                roll = $urandom_range(0, 99);
                if (roll < 15 || (cmd != paid_pkg::CMD_INSERT && gen_count == 0))
                    pos = $urandom_range(0, 127);
                else if (roll < 30)
                    pos = (cmd == paid_pkg::CMD_INSERT) ? gen_count + 1 : gen_count;
                else if (roll < 38)
                    pos = 1;
                else
                    pos = $urandom_range(1, (cmd == paid_pkg::CMD_INSERT) ? gen_count + 1
                                                                          : gen_count);

                queue_command(cmd, pos, pick_value(), gen_count);
                commands_waiting[$].gap = no_idle ? 0 : $urandom_range(0, 18);
                commands_waiting[$].wait_drained =
                    (random_done == 0) || (k == 0 && $urandom_range(0, 3) == 0);
                random_done++;
            end
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (commands_waiting.size() != 0 || start)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 8) @(posedge clk);

        if (mismatch_total == 0 && replies_due.size() == 0)
            $display("** positional_array_insert_delete: PASSED **");
        else
            $display("** positional_array_insert_delete: FAILED **");
        $finish;
    end

endmodule
